FILE: rtl/ntofm_pkg.sv
// Shared types and constants for the neutron time-of-flight momentum pipeline.
// Depends on nothing; used by neutron_tof_momentum.
package ntofm_pkg;

	localparam int AngleBits = 16;
	localparam int CordicIter = (AngleBits < 24) ? AngleBits : 24;

	localparam logic [14:0] CQ10 = 15'd30699;
	localparam logic [17:0] MnQ8 = 18'd240530;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [26:0] PSat = 27'd67108864;

	typedef enum logic [1:0] {
		ST_CORRECTED  = 2'd0,
		ST_NOT_FWD    = 2'd1,
		ST_UNPHYSICAL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_OFF_FIRST = 2'd0,
		REG_OFF_INNER = 2'd1,
		REG_OFF_OUTER = 2'd2,
		REG_THRESHOLD = 2'd3
	} reg_idx_t;

	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/neutron_tof_momentum.sv
// Top level of the neutron time-of-flight momentum pipeline.
// Depends on ntofm_pkg; holds the whole datapath in one pipeline.
//
// Usage: a hit is transferred on the rising clock edge where start is high
// and busy is low. busy is held low, so one hit may be transferred in every
// clock cycle. Each hit gives exactly one result, shown for one cycle on
// the result ports with done high. The receiver cannot stall, and none is
// needed: the pipeline never holds back.
//
// Pipeline: Lat = 68 register stages lie between done and the edge
// that transferred the hit. The stages are three front stages (layer select,
// N and D, radicand), 32 square-root stages (one result bit each), one
// numerator stage, 28 restoring-divider stages (one quotient bit each), one
// saturation stage and three multiply stages. The CORDIC rotators (CordicIter
// stages, one iteration each) run alongside from the transfer edge and their
// outputs are delayed to meet p. Throughput is one hit per cycle.
//
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data write the
// offsets and the energy threshold; cfg_ready is always high. Registers are
// sampled at entry, so writes must only happen while the pipeline is empty.
// Reset clears all valid bits and loads the register defaults.
module neutron_tof_momentum
	import ntofm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               in_forward,
	input  logic [19:0]        energy_first,
	input  logic [19:0]        energy_inner,
	input  logic [19:0]        energy_outer,
	input  logic [17:0]        path_length,
	input  logic [15:0]        flight_time,
	input  logic [15:0]        theta,
	input  logic [15:0]        phi,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	output logic               done,
	output logic [1:0]         status,
	output logic [1:0]         layer_used,
	output logic signed [16:0] mom_x,
	output logic signed [16:0] mom_y,
	output logic signed [16:0] mom_z,
	output logic [17:0]        corrected_path
);

	localparam int SqStages  = 32;
	localparam int DivStages = 28;
	localparam int CStages   = CordicIter;
	// Stage map: s1 select/offset, s2 N/D, s3 product, then sqrt, then divide.
	localparam int PStart = 3 + SqStages + 1 + DivStages; // quotient ready
	localparam int MulA   = PStart + 1;                   // saturated p
	localparam int MulB   = MulA + 1;                     // sin*cos products
	localparam int MulC   = MulB + 1;                     // shifted trig
	localparam int Lat    = MulC + 1;                     // p*trig
	localparam int TrigRdy = CStages;

	logic signed [16:0] off_first_q, off_inner_q, off_outer_q;
	logic [19:0]        thr_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_first_q <= '0;
			off_inner_q <= '0;
			off_outer_q <= '0;
			thr_q       <= 20'd10000;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OFF_FIRST: off_first_q <= cfg_data[16:0];
				REG_OFF_INNER: off_inner_q <= cfg_data[16:0];
				REG_OFF_OUTER: off_outer_q <= cfg_data[16:0];
				REG_THRESHOLD: thr_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid shift line, one bit per stage.
	logic [Lat:1] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-1:1], start};
	end

	// Side-band carried along: status, layer, path.
	logic [1:0]  stat_d  [1:Lat];
	logic [1:0]  lay_d   [1:Lat];
	logic [17:0] cpath_d [1:Lat];

	// Stage 1: layer select and saturated offset sum.
	logic [1:0]         lay_c;
	logic signed [16:0] off_c;
	logic signed [19:0] sum_c;
	logic [17:0]        cp_c;
	logic [15:0]        t_s1;
	always_comb begin
		if (energy_first > thr_q) lay_c = 2'd0;
		else if (energy_inner > thr_q) lay_c = 2'd1;
		else if (energy_outer > thr_q) lay_c = 2'd2;
		else lay_c = 2'd0;
		case (lay_c)
			2'd1: off_c = off_inner_q;
			2'd2: off_c = off_outer_q;
			default: off_c = off_first_q;
		endcase
		sum_c = $signed({2'b00, path_length}) + 20'(off_c);
		if (sum_c < 0) cp_c = '0;
		else if (sum_c > 20'sd262143) cp_c = 18'h3FFFF;
		else cp_c = sum_c[17:0];
	end

	// Stage 2 operands N and D, formed from the stage 1 registers.
	logic [27:0] n_c, n_s2;
	logic [30:0] d_c, d_s2;
	assign n_c = {cpath_d[1], 10'd0};
	assign d_c = 31'(t_s1) * 31'(CQ10);

	always_ff @(posedge clk) begin
		t_s1 <= flight_time;
		if (in_forward) begin
			stat_d[1]  <= ST_CORRECTED;
			lay_d[1]   <= lay_c;
			cpath_d[1] <= cp_c;
		end else begin
			stat_d[1]  <= ST_NOT_FWD;
			lay_d[1]   <= 2'd0;
			cpath_d[1] <= path_length;
		end
		// Stage 2 marks hits with zero time or beta at or above one as unphysical.
		if (stat_d[1] == ST_CORRECTED && (t_s1 == 16'd0 || 31'(n_c) >= d_c))
			stat_d[2] <= ST_UNPHYSICAL;
		else
			stat_d[2] <= stat_d[1];
		for (int k = 3; k <= Lat; k++) stat_d[k] <= stat_d[k-1];
		for (int k = 2; k <= Lat; k++) begin
			lay_d[k]   <= lay_d[k-1];
			cpath_d[k] <= cpath_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		n_s2 <= n_c;
		d_s2 <= d_c;
	end

	// Stage 3: radicand (D-N)*(D+N), formed as a single 31x32-bit product.
	logic [30:0] dm_c;
	logic [31:0] dp_c;
	logic [62:0] rad_s3;
	logic [27:0] n_s3;
	assign dm_c = d_s2 - 31'(n_s2);
	assign dp_c = 32'(d_s2) + 32'(n_s2);
	always_ff @(posedge clk) begin
		rad_s3 <= 63'(dm_c) * 63'(dp_c);
		n_s3   <= n_s2;
	end

	// Square root: one result bit per stage.
	logic [63:0] sq_rem [0:SqStages];
	logic [31:0] sq_res [0:SqStages];
	logic [27:0] sq_n   [0:SqStages];
	assign sq_rem[0] = {1'b0, rad_s3};
	assign sq_res[0] = '0;
	assign sq_n[0]   = n_s3;
	for (genvar g = 0; g < SqStages; g++) begin : g_sqrt
		logic [63:0] rem_r;
		logic [31:0] res_r;
		logic [27:0] n_r;
		always_ff @(posedge clk) begin
			// res holds the root bits so far, aligned; bit position 31-g.
			if (sq_rem[g] >= (({32'd0, sq_res[g]} << (32 - g)) |
				(64'd1 << (62 - 2*g)))) begin
				rem_r <= sq_rem[g] - (({32'd0, sq_res[g]} << (32 - g)) |
					(64'd1 << (62 - 2*g)));
				res_r <= sq_res[g] | (32'd1 << (31 - g));
			end else begin
				rem_r <= sq_rem[g];
				res_r <= sq_res[g];
			end
			n_r <= sq_n[g];
		end
		assign sq_rem[g+1] = rem_r;
		assign sq_res[g+1] = res_r;
		assign sq_n[g+1]   = n_r;
	end

	// Numerator MnQ8*N + den/2 and clamp den to at least 1.
	logic [46:0] num_s4;
	logic [31:0] den_s4;
	logic [31:0] den_c;
	assign den_c = (sq_res[SqStages] == 32'd0) ? 32'd1 : sq_res[SqStages];
	always_ff @(posedge clk) begin
		num_s4 <= 47'(sq_n[SqStages]) * 47'(MnQ8) + 47'(den_c >> 1);
		den_s4 <= den_c;
	end

	// Restoring divider, quotient bits 27..0. A quotient of 2^28 or more comes
	// out as all ones, which the saturation stage then clamps.
	logic [46:0] dv_rem [0:DivStages];
	logic [27:0] dv_q   [0:DivStages];
	logic [31:0] dv_den [0:DivStages];
	assign dv_rem[0] = num_s4;
	assign dv_q[0]   = '0;
	assign dv_den[0] = den_s4;
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		localparam int B = DivStages - 1 - g;
		logic [78:0] sub;
		logic [46:0] rem_r;
		logic [27:0] q_r;
		logic [31:0] d_r;
		assign sub = 79'(dv_den[g]) << B;
		always_ff @(posedge clk) begin
			if (79'(dv_rem[g]) >= sub) begin
				rem_r <= dv_rem[g] - sub[46:0];
				q_r   <= dv_q[g] | (28'd1 << B);
			end else begin
				rem_r <= dv_rem[g];
				q_r   <= dv_q[g];
			end
			d_r <= dv_den[g];
		end
		assign dv_rem[g+1] = rem_r;
		assign dv_q[g+1]   = q_r;
		assign dv_den[g+1] = d_r;
	end

	logic [26:0] p_s;
	always_ff @(posedge clk) begin
		p_s <= (dv_q[DivStages] > 28'(PSat)) ? PSat : dv_q[DivStages][26:0];
	end

	// CORDIC for theta and phi, one iteration per stage.
	logic signed [33:0] sin_t, cos_t, sin_p, cos_p;

	logic [1:0]         qt0, qp0;
	logic signed [32:0] zt0, zp0;
	always_comb begin
		logic [31:0] at, ap, dt, dp;
		at = {theta, 16'd0};
		ap = {phi, 16'd0};
		qt0 = 2'((at + 32'h20000000) >> 30);
		qp0 = 2'((ap + 32'h20000000) >> 30);
		dt = at - {qt0, 30'd0};
		dp = ap - {qp0, 30'd0};
		zt0 = $signed({dt[31], dt});
		zp0 = $signed({dp[31], dp});
	end

	logic signed [33:0] cx [0:1][0:CStages];
	logic signed [33:0] cy [0:1][0:CStages];
	logic signed [32:0] cz [0:1][0:CStages];
	logic [1:0]         cq [0:1][0:CStages];
	assign cx[0][0] = CordicGain; assign cy[0][0] = '0;
	assign cz[0][0] = zt0;        assign cq[0][0] = qt0;
	assign cx[1][0] = CordicGain; assign cy[1][0] = '0;
	assign cz[1][0] = zp0;        assign cq[1][0] = qp0;
	for (genvar a = 0; a < 2; a++) begin : g_ang
		for (genvar g = 0; g < CStages; g++) begin : g_it
			logic signed [33:0] xr, yr;
			logic signed [32:0] zr;
			logic [1:0]         qr;
			always_ff @(posedge clk) begin
				if (!cz[a][g][32]) begin
					xr <= cx[a][g] - (cy[a][g] >>> g);
					yr <= cy[a][g] + (cx[a][g] >>> g);
					zr <= cz[a][g] - $signed({1'b0, atan_entry(g)});
				end else begin
					xr <= cx[a][g] + (cy[a][g] >>> g);
					yr <= cy[a][g] - (cx[a][g] >>> g);
					zr <= cz[a][g] + $signed({1'b0, atan_entry(g)});
				end
				qr <= cq[a][g];
			end
			assign cx[a][g+1] = xr;
			assign cy[a][g+1] = yr;
			assign cz[a][g+1] = zr;
			assign cq[a][g+1] = qr;
		end
	end

	logic signed [33:0] sc [0:1];
	logic signed [33:0] cc [0:1];
	for (genvar a = 0; a < 2; a++) begin : g_quad
		logic signed [33:0] s_c, c_c;
		always_comb begin
			case (cq[a][CStages])
				2'd0: begin c_c = cx[a][CStages];  s_c = cy[a][CStages];  end
				2'd1: begin c_c = -cy[a][CStages]; s_c = cx[a][CStages];  end
				2'd2: begin c_c = -cx[a][CStages]; s_c = -cy[a][CStages]; end
				default: begin c_c = cy[a][CStages]; s_c = -cx[a][CStages]; end
			endcase
		end
		assign sc[a] = s_c;
		assign cc[a] = c_c;
	end

	// Delay trig results from stage TrigRdy to stage MulA so they meet p.
	localparam int TDly = MulA - TrigRdy;
	logic signed [33:0] tdl [0:3][0:TDly];
	assign tdl[0][0] = sc[0]; assign tdl[1][0] = cc[0];
	assign tdl[2][0] = sc[1]; assign tdl[3][0] = cc[1];
	for (genvar k = 0; k < TDly; k++) begin : g_tdl
		logic signed [33:0] st_r, ct_r, sp_r, cp_r;
		always_ff @(posedge clk) begin
			st_r <= tdl[0][k];
			ct_r <= tdl[1][k];
			sp_r <= tdl[2][k];
			cp_r <= tdl[3][k];
		end
		assign tdl[0][k+1] = st_r;
		assign tdl[1][k+1] = ct_r;
		assign tdl[2][k+1] = sp_r;
		assign tdl[3][k+1] = cp_r;
	end
	assign sin_t = tdl[0][TDly]; assign cos_t = tdl[1][TDly];
	assign sin_p = tdl[2][TDly]; assign cos_p = tdl[3][TDly];

	// Trig products (one multiply stage), then component products.
	logic signed [67:0] pxt_a, pyt_a;
	logic signed [33:0] pzt_a;
	logic [26:0]        p_a;
	always_ff @(posedge clk) begin
		pxt_a <= sin_t * cos_p;
		pyt_a <= sin_t * sin_p;
		pzt_a <= cos_t;
		p_a   <= p_s;
	end

	// Trig factors stay within about one in Q30, so 32 signed bits hold them.
	logic signed [31:0] tx_b, ty_b, tz_b;
	logic [26:0]        p_b;
	always_ff @(posedge clk) begin
		tx_b <= 32'(pxt_a >>> 30);
		ty_b <= 32'(pyt_a >>> 30);
		tz_b <= 32'(pzt_a);
		p_b  <= p_a;
	end

	logic signed [65:0] mx_c, my_c, mz_c;
	always_ff @(posedge clk) begin
		mx_c <= $signed({1'b0, p_b}) * tx_b;
		my_c <= $signed({1'b0, p_b}) * ty_b;
		mz_c <= $signed({1'b0, p_b}) * tz_b;
	end

	function automatic logic signed [16:0] round_sat(input logic signed [65:0] v);
		logic signed [65:0] r;
		r = (v + (66'sd1 <<< 37)) >>> 38;
		if (r > 66'sd65535) return 17'sd65535;
		if (r < -66'sd65536) return -17'sd65536;
		return r[16:0];
	endfunction

	assign done           = vld_q[Lat];
	assign status         = stat_d[Lat];
	assign layer_used     = lay_d[Lat];
	assign corrected_path = cpath_d[Lat];
	assign mom_x = (stat_d[Lat] == ST_CORRECTED) ? round_sat(mx_c) : '0;
	assign mom_y = (stat_d[Lat] == ST_CORRECTED) ? round_sat(my_c) : '0;
	assign mom_z = (stat_d[Lat] == ST_CORRECTED) ? round_sat(mz_c) : '0;

endmodule
